// File: hdl/bukl_pkg.sv
// Package with the shared types and constants of the bounded unique key list.
package bukl_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int KEY_W         = 32;
   localparam int LIMIT_W       = 5;
   localparam int RSP_COUNT_W   = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DELETE = 1'b1
   } bukl_cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_MISS  = 2'd1,
      STATUS_BOUND = 2'd2
   } bukl_status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_BUSY = 1'b1
   } bukl_state_type;

   // Broadcast from the controller to every cell of the row.
   typedef struct packed {
      logic              insert_commit;
      logic              delete_commit;
      logic [KEY_W-1:0]  probe_key;
   } bukl_cell_ctl_type;

endpackage

// File: hdl/bukl_cell.sv
// One slot of the key row: holds a key, compares it and shifts on a delete.
module bukl_cell (
   input  logic                       clock,
   input  bukl_pkg::bukl_cell_ctl_type ctl,
   input  logic                       occupied,
   input  logic                       slot_free,
   input  logic                       seen_in,
   input  logic [bukl_pkg::KEY_W-1:0] next_key,
   output logic                       seen_out,
   output logic [bukl_pkg::KEY_W-1:0] key_out
);
   import bukl_pkg::*;

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             hit;

   assign hit      = occupied && (key_ff == ctl.probe_key);
   assign seen_out = seen_in || hit;
   assign key_out  = key_ff;

   // A delete moves every slot from the matching one upwards down by one place.
   always_comb begin
      key_in = key_ff;
      if (ctl.insert_commit && slot_free) begin
         key_in = ctl.probe_key;
      end else if (ctl.delete_commit && seen_out) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// File: hdl/bounded_unique_key_list.sv
// Top level of the bounded unique key list: controller and a row of key cells.
//
// Holds up to DEPTH distinct 32-bit keys in insertion order, limited further by
// the list_limit register (written through the csr_ channel, reset value 16).
// Every command beat is captured in ST_IDLE, and in ST_BUSY all cells compare
// the key in parallel, the row is updated and the status and new count are
// registered on the rsp_ side; ST_BUSY is held while an earlier result still
// waits for rsp_ready. The next command is taken once that result is registered,
// even while it still waits for rsp_ready, so a new command is not taken before
// the last one is through ST_BUSY. The key storage has no reset; only the count
// and control are cleared.
module bounded_unique_key_list #(
   parameter int DEPTH = bukl_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bukl_pkg::LIMIT_W-1:0]   csr_list_limit,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic signed [bukl_pkg::KEY_W-1:0] req_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [bukl_pkg::RSP_COUNT_W-1:0] rsp_entry_count
);
   import bukl_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
   localparam int XW = (LW > RSP_COUNT_W) ? LW : RSP_COUNT_W;

   bukl_state_type     state_ff, state_in;
   bukl_cmd_type       cmd_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   bukl_status_type    rsp_status_ff, status_in;
   logic [RSP_COUNT_W-1:0] rsp_count_ff;

   logic               complete;
   logic               at_limit;
   logic               found;
   logic               insert_ok;
   logic               delete_ok;
   logic [XW-1:0]      count_ext;
   bukl_cell_ctl_type  cell_ctl;

   logic [DEPTH:0]     seen;
   logic [KEY_W-1:0]   cell_key [DEPTH];

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs of the controller.
   always_comb begin
      req_ready = 1'b0;
      complete  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_BUSY: complete  = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   // The count never exceeds DEPTH, so comparing with both bounds gives the
   // limit clipped to the built depth.
   assign at_limit = (LW'(count_ff) >= LW'(limit_ff)) || (LW'(count_ff) >= LW'(DEPTH));
   assign found    = seen[DEPTH];

   assign insert_ok = (cmd_ff == CMD_INSERT) && !at_limit && !found;
   assign delete_ok = (cmd_ff == CMD_DELETE) && (count_ff != '0) && found;

   always_comb begin
      unique case (cmd_ff)
         CMD_INSERT: begin
            if (at_limit) begin
               status_in = STATUS_BOUND;
            end else if (found) begin
               status_in = STATUS_MISS;
            end else begin
               status_in = STATUS_DONE;
            end
         end
         CMD_DELETE: begin
            if (count_ff == '0) begin
               status_in = STATUS_BOUND;
            end else if (!found) begin
               status_in = STATUS_MISS;
            end else begin
               status_in = STATUS_DONE;
            end
         end
         default: status_in = STATUS_BOUND;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (complete && insert_ok) begin
         count_in = count_ff + CW'(1);
      end else if (complete && delete_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_ext = XW'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (complete) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign cell_ctl.insert_commit = complete && insert_ok;
   assign cell_ctl.delete_commit = complete && delete_ok;
   assign cell_ctl.probe_key     = key_ff;

   assign seen[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bukl_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .occupied  (CW'(i) < count_ff),
         .slot_free (CW'(i) == count_ff),
         .seen_in   (seen[i]),
         .next_key  ((i == DEPTH - 1) ? cell_key[i] : cell_key[(i + 1) % DEPTH]),
         .seen_out  (seen[i + 1]),
         .key_out   (cell_key[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_list_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= bukl_cmd_type'(req_cmd);
         key_ff <= req_key;
      end
      if (complete) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_ext[RSP_COUNT_W-1:0];
      end
   end

endmodule

// File: bench/bounded_unique_key_list_tb.sv
// Self-checking testbench for the bounded unique key list, with its own list predictor.
`timescale 1ns / 100ps

module bounded_unique_key_list_tb;

   import bukl_pkg::*;

   localparam int LIST_DEPTH  = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;
   localparam int POOL_SIZE   = 32;

   typedef struct {
      bukl_cmd_type              cmd;
      logic [KEY_W-1:0]          key;
      bukl_status_type           status;
      logic [RSP_COUNT_W-1:0]    count;
   } list_result_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [LIMIT_W-1:0]       csr_list_limit;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_cmd;
   logic signed [KEY_W-1:0]  req_key;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [1:0]               rsp_status;
   logic [RSP_COUNT_W-1:0]   rsp_entry_count;

   // Predictor state: the keys held in order, their number and the limit register.
   logic [KEY_W-1:0]         held_keys [LIST_DEPTH];
   int                       held_count;
   int                       limit_shadow;

   logic [KEY_W-1:0]         key_pool [POOL_SIZE];
   list_result_type          pending_results [$];
   int                       mismatch_count;
   int                       cycle_count = 0;
   int                       hold_cycles;
   bit                       req_idle_on;
   bit                       rsp_idle_on;

   bounded_unique_key_list u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_list_limit  (csr_list_limit),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bounded_unique_key_list_tb: FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Works out the status and count of one command and updates the predicted list.
   function automatic void predict_command(input bukl_cmd_type cmd,
                                           input logic [KEY_W-1:0] key,
                                           output bukl_status_type status,
                                           output logic [RSP_COUNT_W-1:0] count);
      int eff_limit;
      int pos;
      eff_limit = (limit_shadow > LIST_DEPTH) ? LIST_DEPTH : limit_shadow;
      pos = -1;
      for (int slot = 0; slot < held_count; slot++)
         if (pos < 0 && held_keys[slot] == key) pos = slot;
      if (cmd == CMD_INSERT) begin
         if (held_count >= eff_limit)
            status = STATUS_BOUND;
         else if (pos >= 0)
            status = STATUS_MISS;
         else begin
            held_keys[held_count] = key;
            held_count++;
            status = STATUS_DONE;
         end
      end else begin
         if (held_count == 0)
            status = STATUS_BOUND;
         else if (pos < 0)
            status = STATUS_MISS;
         else begin
            for (int slot = pos; slot + 1 < held_count; slot++)
               held_keys[slot] = held_keys[slot + 1];
            held_count--;
            status = STATUS_DONE;
         end
      end
      count = held_count[RSP_COUNT_W-1:0];
   endfunction

   // Sends one command beat; valid stays high afterwards until the next beat or a pause.
   task automatic send_command(input bukl_cmd_type cmd, input logic [KEY_W-1:0] key);
      list_result_type entry;
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd   = cmd;
      req_key   = key;
      do @(posedge clock); while (!req_ready);
      entry.cmd = cmd;
      entry.key = key;
      predict_command(cmd, key, entry.status, entry.count);
      pending_results.push_back(entry);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_list_limit(input logic [LIMIT_W-1:0] value);
      @(negedge clock);
      csr_valid      = 1'b1;
      csr_list_limit = value;
      do @(posedge clock); while (!csr_ready);
      limit_shadow = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Deletes mostly name a held key, inserts mostly draw on a small pool so that
   // duplicates and full lists turn up often.
   function automatic logic [KEY_W-1:0] choose_key(input bukl_cmd_type cmd);
      if (cmd == CMD_DELETE && held_count > 0 && $urandom_range(0, 99) < 75)
         return held_keys[$urandom_range(0, held_count - 1)];
      if ($urandom_range(0, 99) < 70)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   task automatic send_random_commands(input int total, input int insert_pct);
      bukl_cmd_type cmd;
      for (int n = 0; n < total; n++) begin
         cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
         send_command(cmd, choose_key(cmd));
      end
   endtask

   always @(posedge clock) begin : rsp_check
      list_result_type oldest;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0)
            report_mismatch("result beat with no command outstanding");
         else begin
            oldest = pending_results.pop_front();
            if (rsp_status !== oldest.status)
               report_mismatch($sformatf("%s key %h: status %0d, predicted %0d",
                  oldest.cmd.name(), oldest.key, rsp_status, oldest.status));
            if (rsp_entry_count !== oldest.count)
               report_mismatch($sformatf("%s key %h: count %0d, predicted %0d",
                  oldest.cmd.name(), oldest.key, rsp_entry_count, oldest.count));
         end
      end
   end

   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            repeat (hold_cycles - 1) @(negedge clock);
            hold_cycles = 0;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 18);
            rsp_ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else
            rsp_ready = 1'b1;
      end
   end

   task automatic test_directed_updates();
      send_command(CMD_DELETE, 32'h0000_0005);
      send_command(CMD_INSERT, 32'h8000_0000);
      send_command(CMD_INSERT, 32'h7FFF_FFFF);
      send_command(CMD_INSERT, 32'h0000_0000);
      send_command(CMD_INSERT, 32'hFFFF_FFFF);
      send_command(CMD_INSERT, 32'h7FFF_FFFF);
      send_command(CMD_DELETE, 32'h0000_0001);
      // Removing a middle entry has to close the gap behind it.
      send_command(CMD_DELETE, 32'h7FFF_FFFF);
      send_command(CMD_DELETE, 32'h8000_0000);
      send_command(CMD_DELETE, 32'hFFFF_FFFF);
      send_command(CMD_INSERT, 32'h8000_0000);
      wait_results_drained();
   endtask

   task automatic test_directed_limits();
      // The limit drops below the number held: the keys stay and remain deletable.
      write_list_limit(5'd1);
      send_command(CMD_INSERT, 32'h0000_0005);
      send_command(CMD_DELETE, 32'h8000_0000);
      send_command(CMD_INSERT, 32'h0000_0007);
      send_command(CMD_DELETE, 32'h0000_0000);
      send_command(CMD_INSERT, 32'h0000_0007);
      wait_results_drained();
      write_list_limit(5'd0);
      send_command(CMD_INSERT, 32'h0000_0009);
      send_command(CMD_DELETE, 32'h0000_0007);
      send_command(CMD_DELETE, 32'h0000_0007);
      wait_results_drained();
   endtask

   task automatic test_random_traffic();
      logic [LIMIT_W-1:0] phase_limits [12];
      phase_limits = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd0, 5'd5,
                       5'd17, 5'd16, 5'd3, 5'd8, 5'd15, 5'd31};
      for (int phase = 0; phase < 12; phase++) begin
         wait_results_drained();
         write_list_limit(phase_limits[phase]);
         req_idle_on = (phase % 4 != 3);
         rsp_idle_on = (phase % 3 != 2);
         send_random_commands(50, (phase % 2 == 0) ? 75 : 35);
      end
      wait_results_drained();
   endtask

   // A long receiver hold-off while beats keep coming fills the block and stalls its input.
   task automatic test_output_backpressure();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_cycles = 150;
      send_random_commands(30, 60);
      wait_results_drained();
   endtask

   task automatic test_steady_stream();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      write_list_limit(5'd16);
      send_random_commands(60, 50);
      wait_results_drained();
   endtask

   initial begin
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_list_limit = '0;
      req_valid      = 1'b0;
      req_cmd        = CMD_INSERT;
      req_key        = '0;
      held_count     = 0;
      limit_shadow   = LIMIT_RESET;
      mismatch_count = 0;
      hold_cycles    = 0;
      req_idle_on    = 1'b1;
      rsp_idle_on    = 1'b1;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int n = 4; n < POOL_SIZE; n++) key_pool[n] = $urandom;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_updates();
      test_directed_limits();
      test_random_traffic();
      test_output_backpressure();
      test_steady_stream();

      // Leave room for any stray result beat to show up.
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("bounded_unique_key_list_tb: PASS");
      else
         $display("bounded_unique_key_list_tb: FAIL");
      $finish;
   end

endmodule
